// ===== rtl/ffcba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffcba_pkg
// Shared types and constants of the first-fit contiguous block allocator.
// ----------------------------------------------------------------------------
package ffcba_pkg;

  // map size and derived widths
  localparam int NUM_BLOCKS = 128;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_RAW_W  = $clog2(NUM_BLOCKS + 1);
  // wide enough for block counts, positions and the map size itself
  localparam int CMP_W      = ((CNT_RAW_W > 8) ? CNT_RAW_W : 8) + 1;

  // payload widths
  localparam int OP_W    = 1;
  localparam int COUNT_W = 8;
  localparam int FIRST_W = 7;
  localparam int START_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // broadcast control for the ring of map cells
  typedef struct packed {
    logic             shift;     // rotate the ring by one cell
    logic             clr;       // mark the tail cells used while shifting
    logic [CMP_W-1:0] clr_from;  // first cell index that gets marked used
  } cell_ctl_t;

endpackage

// ===== rtl/ffcba_if.sv =====
// ----------------------------------------------------------------------------
// ffcba request / response interfaces
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffcba_req_if import ffcba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COUNT_W-1:0] block_count;
  logic [FIRST_W-1:0] first_block;

  modport source (output valid, operation, block_count, first_block, input ready);
  modport sink   (input valid, operation, block_count, first_block, output ready);
endinterface

interface ffcba_rsp_if import ffcba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] run_start;
  logic               ok;

  modport source (output valid, run_start, ok, input ready);
  modport sink   (input valid, run_start, ok, output ready);
endinterface

// ===== rtl/first_fit_contiguous_block_allocator.sv =====
// Timing: after acceptance the ring rotates one cell per cycle past the
//   sequencer for one full rotation, then the response is loaded into the
//   output register, waiting while a previous response is still unaccepted.
//   A new transaction is accepted only after the response is loaded, so
//   transactions never overlap.
// Reset: asynchronous, active low; every block becomes free, no response pending.
// ----------------------------------------------------------------------------
// first_fit_contiguous_block_allocator
// First-fit allocator of contiguous block runs over a free map kept in a ring.
// ----------------------------------------------------------------------------
module first_fit_contiguous_block_allocator import ffcba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffcba_req_if.sink   req_i,
  ffcba_rsp_if.source rsp_o
);

  // the free map lives in a ring of cells that rotates toward cell 0;
  // after k shifts cell 0 holds block k, so the sequencer sees the map
  // one block per cycle in ascending order and the ring is back in place
  // after NUM_BLOCKS shifts
  //
  // allocate: when a run of the requested length ends at the head, its
  // blocks sit in the top cells after the shift, so all cells from
  // NUM_BLOCKS - count upward load a used bit in that same cycle
  //
  // free: the head bit re-enters at the tail, forced free when its block
  // lies inside the requested run; blocks past the map never show up

  cell_ctl_t             cell_ctl;
  logic                  tail_set;
  logic [NUM_BLOCKS-1:0] free_bits;

  ffcba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .head_free_i (free_bits[0]),
    .ctl_o       (cell_ctl),
    .tail_set_o  (tail_set)
  );

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic nbr;
    logic set;

    // last cell closes the ring and takes the (possibly freed) head bit
    if (i == NUM_BLOCKS - 1) begin : g_tail
      assign nbr = free_bits[0];
      assign set = tail_set;
    end else begin : g_body
      assign nbr = free_bits[i+1];
      assign set = 1'b0;
    end

    ffcba_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .idx_i  (CMP_W'(i)),
      .set_i  (set),
      .nbr_i  (nbr),
      .free_o (free_bits[i])
    );
  end

endmodule

// ===== rtl/ffcba_cell.sv =====
// ----------------------------------------------------------------------------
// ffcba_cell
// One free-map bit of the rotating ring; takes its neighbor's bit on shift.
// ----------------------------------------------------------------------------
module ffcba_cell import ffcba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [CMP_W-1:0] idx_i,
  input  logic             set_i,
  input  logic             nbr_i,
  output logic             free_o
);

  logic free_q, free_d;

  always_comb begin
    free_d = free_q;
    if (ctl_i.shift) begin
      if (ctl_i.clr && (idx_i >= ctl_i.clr_from)) begin
        free_d = 1'b0;
      end else begin
        free_d = nbr_i | set_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
    end else begin
      free_q <= free_d;
    end
  end

  assign free_o = free_q;

endmodule

// ===== rtl/ffcba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffcba_ctrl
// Sequencer: watches the ring head, counts free runs, drives marking.
// ----------------------------------------------------------------------------
module ffcba_ctrl import ffcba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffcba_req_if.sink   req,
  ffcba_rsp_if.source rsp,
  input  logic      head_free_i,
  output cell_ctl_t ctl_o,
  output logic      tail_set_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [CMP_W-1:0]   run_q, run_d;
  logic               found_q, found_d;
  logic [START_W-1:0] start_q, start_d;
  logic [OP_W-1:0]    op_q;
  logic [CMP_W-1:0]   cnt_q;
  logic [CMP_W-1:0]   first_q;
  logic               rsp_valid_q;
  logic [START_W-1:0] rsp_start_q;
  logic               rsp_ok_q;

  logic             accept;
  logic             scan;
  logic             last_pos;
  logic             load_rsp;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] run_inc;
  logic             cnt_ok;
  logic             hit;
  logic             in_range;
  logic [CMP_W-1:0] start_full;

  assign pos_ext    = CMP_W'(pos_q);
  assign run_inc    = run_q + CMP_W'(1);
  assign cnt_ok     = (cnt_q != '0) && (cnt_q <= CMP_W'(NUM_BLOCKS));
  assign last_pos   = (pos_q == IDX_W'(NUM_BLOCKS - 1));
  assign start_full = pos_ext + CMP_W'(1) - cnt_q;
  assign in_range   = (pos_ext >= first_q) && ((pos_ext - first_q) < cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req.valid) state_d = ST_SCAN;
      ST_SCAN: if (last_pos) state_d = ST_RESP;
      ST_RESP: if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = 1'b0;
    scan      = 1'b0;
    load_rsp  = 1'b0;
    case (state_q)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: scan = 1'b1;
      ST_RESP: load_rsp = !rsp_valid_q || rsp.ready;
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;
  assign hit    = scan && (op_q == OP_ALLOC) && cnt_ok && !found_q &&
                  head_free_i && (run_inc == cnt_q);

  assign ctl_o.shift    = scan;
  assign ctl_o.clr      = hit;
  assign ctl_o.clr_from = CMP_W'(NUM_BLOCKS) - cnt_q;
  assign tail_set_o     = scan && (op_q == OP_FREE) && in_range;

  // scan bookkeeping
  always_comb begin
    pos_d   = pos_q;
    run_d   = run_q;
    found_d = found_q;
    start_d = start_q;
    if (accept) begin
      pos_d   = '0;
      run_d   = '0;
      found_d = 1'b0;
      start_d = '0;
    end else if (scan) begin
      pos_d = pos_q + IDX_W'(1);
      run_d = head_free_i ? run_inc : '0;
      if (hit) begin
        found_d = 1'b1;
        start_d = start_full[START_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      found_q <= found_d;
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    if (accept) begin
      op_q    <= req.operation;
      cnt_q   <= CMP_W'(req.block_count);
      first_q <= CMP_W'(req.first_block);
    end
    if (load_rsp) begin
      rsp_start_q <= (op_q == OP_ALLOC) ? start_q : '0;
      rsp_ok_q    <= (op_q == OP_FREE) || found_q;
    end
  end

  assign rsp.valid     = rsp_valid_q;
  assign rsp.run_start = rsp_start_q;
  assign rsp.ok        = rsp_ok_q;

endmodule
